### rtl/core/topology_change_fsm_unit_defines.svh
// assertion macros for the topology change machine
`ifndef TOPOLOGY_CHANGE_FSM_UNIT_DEFINES_SVH
`define TOPOLOGY_CHANGE_FSM_UNIT_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define TCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("topology change unit check failed");

// consequent holds in the cycle after the antecedent
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("topology change unit check failed");

`endif

### rtl/core/tcfsm_pkg.sv
// types and constants shared by the topology change machine
`default_nettype none
package tcfsm_pkg;

    typedef enum logic [2:0] {
        ST_INACTIVE     = 3'd0,
        ST_LEARNING     = 3'd1,
        ST_DETECTED     = 3'd2,
        ST_ACTIVE       = 3'd3,
        ST_NOTIFY_TCN   = 3'd4,
        ST_NOTIFY_TC    = 3'd5,
        ST_PROPAGATING  = 3'd6,
        ST_ACKNOWLEDGED = 3'd7
    } state_t;

    localparam logic [1:0] ROLE_ROOT       = 2'd0;
    localparam logic [1:0] ROLE_DESIGNATED = 2'd1;
    localparam logic [1:0] ROLE_MASTER     = 2'd2;
    localparam logic [1:0] ROLE_OTHER      = 2'd3;

    localparam logic [1:0] DETECT_NONE  = 2'd0;
    localparam logic [1:0] DETECT_START = 2'd1;
    localparam logic [1:0] DETECT_CLEAR = 2'd2;

    localparam logic [1:0] FLUSH_NONE      = 2'd0;
    localparam logic [1:0] FLUSH_IMMEDIATE = 2'd1;
    localparam logic [1:0] FLUSH_AGEING    = 2'd2;

    localparam logic [1:0] INFO_NONE = 2'd0;
    localparam logic [1:0] INFO_CIST = 2'd1;
    localparam logic [1:0] INFO_MSTI = 2'd2;

    typedef struct packed {
        logic       begin_req;
        logic       is_cist;
        logic [1:0] port_role;
        logic       forward;
        logic       learn;
        logic       learning_now;
        logic       oper_edge;
        logic       got_tc;
        logic       got_tcn;
        logic       got_tc_ack;
        logic       got_propagate;
    } in_item_t;

    typedef struct packed {
        logic [2:0] fsm_now;
        logic       moved;
        logic       start_tc_timer;
        logic       clear_tc_timer;
        logic [1:0] detect_cmd;
        logic       propagate_out;
        logic [1:0] flush_cmd;
        logic [1:0] new_info_cmd;
        logic       notified_event;
        logic       tc_ack_out;
    } out_item_t;

endpackage
`default_nettype wire

### rtl/core/tcfsm_in_stage.sv
// input register stage
`default_nettype none
module tcfsm_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcfsm_pkg::in_item_t in_item,
    input  logic                advance,
    output logic                held_valid,
    output tcfsm_pkg::in_item_t held_item
);
    import tcfsm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule
`default_nettype wire

### rtl/core/tcfsm_core.sv
// state, flags and single-step evaluation of the topology change machine
`default_nettype none
module tcfsm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 advance,
    input  tcfsm_pkg::in_item_t  item,
    output tcfsm_pkg::out_item_t result
);
    import tcfsm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   move;
    logic   rapid_mode_reg;
    logic   rcvd_tc_reg;
    logic   rcvd_tc_next;
    logic   rcvd_tcn_reg;
    logic   rcvd_tcn_next;
    logic   rcvd_ack_reg;
    logic   rcvd_ack_next;
    logic   prop_reg;
    logic   prop_next;
    logic   send_ack_reg;
    logic   send_ack_next;
    logic   tc_f;
    logic   tcn_f;
    logic   ack_f;
    logic   prop_f;
    logic   any_flag;
    logic   active_role;
    logic [1:0] flush_kind;

    assign tc_f        = rcvd_tc_reg || item.got_tc;
    assign tcn_f       = rcvd_tcn_reg || item.got_tcn;
    assign ack_f       = rcvd_ack_reg || item.got_tc_ack;
    assign prop_f      = prop_reg || item.got_propagate;
    assign any_flag    = tc_f || tcn_f || ack_f || prop_f;
    assign active_role = (item.port_role != ROLE_OTHER);
    assign flush_kind  = rapid_mode_reg ? FLUSH_IMMEDIATE : FLUSH_AGEING;

    // next state
    always_comb
    begin
        move       = 1'b0;
        state_next = state_reg;
        if (item.begin_req)
        begin
            if (state_reg != ST_INACTIVE)
            begin
                move       = 1'b1;
                state_next = ST_INACTIVE;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_ACTIVE:
                begin
                    priority if (!active_role || item.oper_edge)
                    begin
                        move       = 1'b1;
                        state_next = ST_LEARNING;
                    end
                    else if (tcn_f)
                    begin
                        move       = 1'b1;
                        state_next = ST_NOTIFY_TCN;
                    end
                    else if (tc_f)
                    begin
                        move       = 1'b1;
                        state_next = ST_NOTIFY_TC;
                    end
                    else if (prop_f)
                    begin
                        move       = 1'b1;
                        state_next = ST_PROPAGATING;
                    end
                    else if (ack_f)
                    begin
                        move       = 1'b1;
                        state_next = ST_ACKNOWLEDGED;
                    end
                    else
                    begin
                        move       = 1'b0;
                        state_next = state_reg;
                    end
                end
                ST_INACTIVE:
                begin
                    if (item.learn)
                    begin
                        move       = 1'b1;
                        state_next = ST_LEARNING;
                    end
                end
                ST_LEARNING:
                begin
                    priority if (active_role && item.forward && !item.oper_edge)
                    begin
                        move       = 1'b1;
                        state_next = ST_DETECTED;
                    end
                    else if (!active_role && !(item.learn || item.learning_now) && !any_flag)
                    begin
                        move       = 1'b1;
                        state_next = ST_INACTIVE;
                    end
                    else if (any_flag)
                    begin
                        move       = 1'b1;
                        state_next = ST_LEARNING;
                    end
                    else
                    begin
                        move       = 1'b0;
                        state_next = state_reg;
                    end
                end
                ST_NOTIFY_TCN:
                begin
                    move       = 1'b1;
                    state_next = ST_NOTIFY_TC;
                end
                ST_DETECTED, ST_NOTIFY_TC, ST_PROPAGATING, ST_ACKNOWLEDGED:
                begin
                    move       = 1'b1;
                    state_next = ST_ACTIVE;
                end
                default:
                begin
                    move       = 1'b0;
                    state_next = state_reg;
                end
            endcase
        end
    end

    // entry actions and result
    always_comb
    begin
        rcvd_tc_next  = tc_f;
        rcvd_tcn_next = tcn_f;
        rcvd_ack_next = ack_f;
        prop_next     = prop_f;
        send_ack_next = send_ack_reg;
        result        = '0;
        result.moved  = move;
        if (move)
        begin
            unique case (state_next)
                ST_INACTIVE:
                begin
                    if (!item.oper_edge)
                    begin
                        result.flush_cmd = flush_kind;
                    end
                    result.detect_cmd     = DETECT_CLEAR;
                    result.clear_tc_timer = 1'b1;
                    if (item.is_cist)
                    begin
                        send_ack_next = 1'b0;
                    end
                end
                ST_LEARNING:
                begin
                    if (item.is_cist)
                    begin
                        rcvd_tcn_next = 1'b0;
                        rcvd_ack_next = 1'b0;
                    end
                    rcvd_tc_next = 1'b0;
                    prop_next    = 1'b0;
                end
                ST_DETECTED:
                begin
                    result.start_tc_timer = 1'b1;
                    result.propagate_out  = 1'b1;
                    result.detect_cmd     = DETECT_START;
                    result.new_info_cmd   = item.is_cist ? INFO_CIST : INFO_MSTI;
                end
                ST_NOTIFY_TCN:
                begin
                    result.start_tc_timer = 1'b1;
                end
                ST_NOTIFY_TC:
                begin
                    result.notified_event = 1'b1;
                    if (item.is_cist)
                    begin
                        rcvd_tcn_next = 1'b0;
                    end
                    rcvd_tc_next = 1'b0;
                    if (item.is_cist && (item.port_role == ROLE_DESIGNATED))
                    begin
                        send_ack_next = 1'b1;
                    end
                    result.propagate_out = 1'b1;
                end
                ST_PROPAGATING:
                begin
                    result.start_tc_timer = 1'b1;
                    if (!item.oper_edge)
                    begin
                        result.flush_cmd = flush_kind;
                    end
                    prop_next = 1'b0;
                end
                ST_ACKNOWLEDGED:
                begin
                    result.clear_tc_timer = 1'b1;
                    rcvd_ack_next         = 1'b0;
                end
                ST_ACTIVE:
                begin
                    result.moved = 1'b1;
                end
                default:
                begin
                    result.moved = 1'b1;
                end
            endcase
        end
        result.fsm_now    = state_next;
        result.tc_ack_out = send_ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INACTIVE;
            rcvd_tc_reg  <= 1'b0;
            rcvd_tcn_reg <= 1'b0;
            rcvd_ack_reg <= 1'b0;
            prop_reg     <= 1'b0;
            send_ack_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            rcvd_tc_reg  <= rcvd_tc_next;
            rcvd_tcn_reg <= rcvd_tcn_next;
            rcvd_ack_reg <= rcvd_ack_next;
            prop_reg     <= prop_next;
            send_ack_reg <= send_ack_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rapid_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            rapid_mode_reg <= cfg_wdata;
        end
    end

endmodule
`default_nettype wire

### rtl/core/tcfsm_out_stage.sv
// result register stage
`default_nettype none
module tcfsm_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  tcfsm_pkg::out_item_t result,
    output logic                 out_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcfsm_pkg::out_item_t out_item
);
    import tcfsm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = advance || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

### rtl/core/topology_change_fsm_unit.sv
// top level of the per-port topology change machine
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      s_axis_tdata  (16 bits)
//   m_axis    out  m_axis_tvalid/tready      m_axis_tdata  (16 bits)
//   cfg       in   cfg_we                    cfg_wdata     (rapid_mode)
//
// one word per cycle sustained while m_axis_tready stays high; a word is held in the input register,
// is evaluated there and is loaded into the result register once that register is free
// rst_n clears the valid bits, the state (inactive), all flags, and rapid_mode to 1
// a stalled result register holds the input register, which then drops s_axis_tready
`default_nettype none
module topology_change_fsm_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // begin_req, is_cist, port_role[1:0], forward, learn, learning_now, oper_edge,
    // got_tc, got_tcn, got_tc_ack, got_propagate, 4 bits unused
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fsm_now[2:0], moved, start_tc_timer, clear_tc_timer, detect_cmd[1:0],
    // propagate_out, flush_cmd[1:0], new_info_cmd[1:0], notified_event, tc_ack_out, 1 bit zero
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import tcfsm_pkg::*;

    in_item_t  in_item;
    in_item_t  held_item;
    out_item_t result;
    out_item_t out_item;
    logic      held_valid;
    logic      out_free;
    logic      advance;

    // struct members in declaration order, begin_req first
    assign in_item = {s_axis_tdata[0],
                      s_axis_tdata[1],
                      s_axis_tdata[3:2],
                      s_axis_tdata[4],
                      s_axis_tdata[5],
                      s_axis_tdata[6],
                      s_axis_tdata[7],
                      s_axis_tdata[8],
                      s_axis_tdata[9],
                      s_axis_tdata[10],
                      s_axis_tdata[11]};

    assign advance = held_valid && out_free;

    tcfsm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tcfsm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (held_item),
        .result    (result)
    );

    tcfsm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {1'b0,
                           out_item.tc_ack_out,
                           out_item.notified_event,
                           out_item.new_info_cmd,
                           out_item.flush_cmd,
                           out_item.propagate_out,
                           out_item.detect_cmd,
                           out_item.clear_tc_timer,
                           out_item.start_tc_timer,
                           out_item.moved,
                           out_item.fsm_now};

endmodule
`default_nettype wire

### rtl/core/tcfsm_checker.sv
// port-level checks for the topology change machine
`default_nettype none
`include "topology_change_fsm_unit_defines.svh"
module tcfsm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata
);
    import tcfsm_pkg::*;

    logic       out_stall;
    logic       out_still;
    logic       out_moved;
    logic [2:0] out_state;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_still = m_axis_tvalid && !m_axis_tdata[3];
    assign out_moved = m_axis_tvalid && m_axis_tdata[3];
    assign out_state = m_axis_tdata[2:0];

    // stalled result word holds
    `TCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // no transition means no command pulses
    `TCF_ASSERT_SAME(a_idle_quiet, clk, rst_n, out_still, m_axis_tdata[13:4] == 10'd0)

    // entering notified tc always signals the event and raises propagate_out
    `TCF_ASSERT_SAME(a_notified, clk, rst_n, out_moved && (out_state == ST_NOTIFY_TC), m_axis_tdata[13] && m_axis_tdata[8])

    // entering inactive clears the timer and tc detection
    `TCF_ASSERT_SAME(a_inactive, clk, rst_n, out_moved && (out_state == ST_INACTIVE), m_axis_tdata[5] && (m_axis_tdata[7:6] == DETECT_CLEAR))

endmodule

bind topology_change_fsm_unit tcfsm_checker u_tcfsm_checker (.*);
`default_nettype wire
